// File: src/csrast_pkg.sv
// ----------------------------------------------------------------------------
// csrast_pkg - circle sprite rasteriser shared types and constants
// Word layouts of the input and result channels, operation codes and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package csrast_pkg;

  // operation codes carried by an input word
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // configuration register map (word index, from paddr[2])
  localparam logic REG_IMAGE_TOP = 1'b0;

  localparam logic [7:0]  IMAGE_TOP_RESET = 8'd32;
  localparam logic [16:0] INDEX_LIMIT     = 17'd16384;

  typedef struct packed {
    logic        operation;
    logic [7:0]  old_x;
    logic [7:0]  old_y;
    logic [7:0]  center_x;
    logic [7:0]  center_y;
    logic [5:0]  circle_radius;
    logic [15:0] fg_color;
    logic [15:0] back_color;
    logic        fill_mode;
    logic        use_image;
  } in_t;

  typedef struct packed {
    logic [6:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        from_image;
    logic [13:0] image_index;
    logic        index_valid;
    logic        last_pixel;
  } out_t;

endpackage

// File: src/circle_sprite_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_sprite_rasterizer - circle sprite pixel generator
// Loads a circle draw on a start word, then emits one pixel of the clamped
// union of the old and new bounding boxes per tick word, in row-major order.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Word
//   input     in_valid / in_ready / in_data           in_t (start or tick)
//   result    out_valid / out_ready / out_data        out_t (one pixel)
//   config    psel penable pwrite paddr pwdata        image_top_row at 0x0
//             prdata pready
//
// One word is taken per cycle. A tick while busy yields its pixel in the
// output register on the next edge; starts and idle ticks yield nothing.
// Between the scan registers and the output register sit the pixel test (two
// 8-bit squares, a sum, two compares) and the image index (constant multiply).
// Reset (rst_n, synchronous) leaves the block idle with image_top_row at 32.
// A stalled result holds the output register; input is taken while it is
// empty or being drained the same cycle.
//
module circle_sprite_rasterizer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 160,
  parameter int IMAGE_WIDTH   = 128,
  parameter int MAX_RADIUS    = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csrast_pkg::in_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csrast_pkg::out_t    out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import csrast_pkg::*;

  localparam logic [9:0] SCR_W   = 10'(SCREEN_WIDTH);
  localparam logic [9:0] SCR_H   = 10'(SCREEN_HEIGHT);
  localparam logic [8:0] IMG_W   = 9'(IMAGE_WIDTH);
  localparam logic [6:0] RAD_MAX = 7'(MAX_RADIUS);

  // Configuration
  logic [7:0] image_top_r;

  // Draw state
  logic        busy_r,     busy_nxt;
  logic [7:0]  box_left_r, box_left_nxt;
  logic [7:0]  box_right_r, box_right_nxt;
  logic [7:0]  box_bottom_r, box_bottom_nxt;
  logic [7:0]  scan_col_r, scan_col_nxt;
  logic [7:0]  scan_row_r, scan_row_nxt;
  logic [7:0]  cx_r,       cx_nxt;
  logic [7:0]  cy_r,       cy_nxt;
  logic        rad_zero_r, rad_zero_nxt;
  logic [11:0] outer_r,    outer_nxt;
  logic [11:0] inner_r,    inner_nxt;
  logic [15:0] fg_r,       fg_nxt;
  logic [15:0] bg_r,       bg_nxt;
  logic        fill_r,     fill_nxt;
  logic        image_r,    image_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r,  out_data_nxt;

  logic in_fire, start_fire, tick_fire;

  // Start path
  logic [7:0]       min_x, max_x, min_y, max_y;
  logic [5:0]       rad;
  logic signed [9:0] lo_x_s, lo_y_s;
  logic [7:0]       lo_x, lo_y;
  logic [9:0]       hi_x_raw, hi_y_raw, hi_x, hi_y;
  logic [5:0]       rad_m1;
  logic             box_ok;

  // Pixel path
  logic [7:0]  dx, dy;
  logic [15:0] dx2, dy2;
  logic [16:0] d2;
  logic        in_outer, on_circle, from_img;
  logic [16:0] img_index;
  logic        img_hit;
  logic        last;

  assign pready   = 1'b1;
  assign prdata   = {24'd0, image_top_r};
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign start_fire = in_fire && (in_data.operation == OP_START);
  assign tick_fire  = in_fire && (in_data.operation == OP_TICK) && busy_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration write at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_top_r <= IMAGE_TOP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_IMAGE_TOP)) begin
      image_top_r <= pwdata[7:0];
    end
  end

  // Start: clamp the union of both boxes to the screen
  always_comb begin
    rad    = ({1'b0, in_data.circle_radius} > RAD_MAX) ? RAD_MAX[5:0]
                                                       : in_data.circle_radius;
    min_x  = (in_data.old_x < in_data.center_x) ? in_data.old_x : in_data.center_x;
    max_x  = (in_data.old_x < in_data.center_x) ? in_data.center_x : in_data.old_x;
    min_y  = (in_data.old_y < in_data.center_y) ? in_data.old_y : in_data.center_y;
    max_y  = (in_data.old_y < in_data.center_y) ? in_data.center_y : in_data.old_y;
    lo_x_s = $signed({2'b00, min_x}) - $signed({4'b0000, rad});
    lo_y_s = $signed({2'b00, min_y}) - $signed({4'b0000, rad});
    lo_x   = lo_x_s[9] ? 8'd0 : lo_x_s[7:0];
    lo_y   = lo_y_s[9] ? 8'd0 : lo_y_s[7:0];
    hi_x_raw = {2'b00, max_x} + {4'b0000, rad};
    hi_y_raw = {2'b00, max_y} + {4'b0000, rad};
    hi_x   = (hi_x_raw > SCR_W) ? SCR_W : hi_x_raw;
    hi_y   = (hi_y_raw > SCR_H) ? SCR_H : hi_y_raw;
    box_ok = (hi_x > {2'b00, lo_x}) && (hi_y > {2'b00, lo_y});
    rad_m1 = rad - 6'd1;
  end

  // Tick: ring/disc test and image addressing for the current scan position
  always_comb begin
    dx  = (scan_col_r > cx_r) ? scan_col_r - cx_r : cx_r - scan_col_r;
    dy  = (scan_row_r > cy_r) ? scan_row_r - cy_r : cy_r - scan_row_r;
    dx2 = 16'(dx) * 16'(dx);
    dy2 = 16'(dy) * 16'(dy);
    d2  = {1'b0, dx2} + {1'b0, dy2};
    in_outer = d2 < {5'd0, outer_r};
    if (rad_zero_r) begin
      on_circle = 1'b0;
    end else if (fill_r) begin
      on_circle = in_outer;
    end else begin
      on_circle = in_outer && (d2 >= {5'd0, inner_r});
    end
    from_img  = !on_circle && image_r;
    img_index = 17'(scan_row_r - image_top_r) * 17'(IMG_W) + {9'd0, scan_col_r};
    img_hit   = (scan_row_r >= image_top_r) && ({1'b0, scan_col_r} < IMG_W)
                && (img_index < INDEX_LIMIT);
    last      = (scan_col_r == box_right_r) && (scan_row_r == box_bottom_r);
  end

  // Next state
  always_comb begin
    busy_nxt       = busy_r;
    box_left_nxt   = box_left_r;
    box_right_nxt  = box_right_r;
    box_bottom_nxt = box_bottom_r;
    scan_col_nxt   = scan_col_r;
    scan_row_nxt   = scan_row_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    rad_zero_nxt   = rad_zero_r;
    outer_nxt      = outer_r;
    inner_nxt      = inner_r;
    fg_nxt         = fg_r;
    bg_nxt         = bg_r;
    fill_nxt       = fill_r;
    image_nxt      = image_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (start_fire) begin
      // load the new draw; an empty box leaves the block idle
      cx_nxt         = in_data.center_x;
      cy_nxt         = in_data.center_y;
      rad_zero_nxt   = (rad == 6'd0);
      outer_nxt      = 12'(rad) * 12'(rad);
      inner_nxt      = 12'(rad_m1) * 12'(rad_m1);
      fg_nxt         = in_data.fg_color;
      bg_nxt         = in_data.back_color;
      fill_nxt       = in_data.fill_mode;
      image_nxt      = in_data.use_image;
      box_left_nxt   = lo_x;
      box_right_nxt  = 8'(hi_x - 10'd1);
      box_bottom_nxt = 8'(hi_y - 10'd1);
      scan_col_nxt   = lo_x;
      scan_row_nxt   = lo_y;
      busy_nxt       = box_ok;
    end else if (tick_fire) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.pixel_x     = scan_col_r[6:0];
      out_data_nxt.pixel_y     = scan_row_r;
      out_data_nxt.pixel_color = on_circle ? fg_r : (from_img ? 16'd0 : bg_r);
      out_data_nxt.from_image  = from_img;
      out_data_nxt.image_index = img_hit ? img_index[13:0] : 14'd0;
      out_data_nxt.index_valid = img_hit;
      out_data_nxt.last_pixel  = last;
      // advance the raster scan
      if (last) begin
        busy_nxt = 1'b0;
      end else if (scan_col_r == box_right_r) begin
        scan_col_nxt = box_left_r;
        scan_row_nxt = scan_row_r + 8'd1;
      end else begin
        scan_col_nxt = scan_col_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and draw parameters: no reset needed
  always_ff @(posedge clk) begin
    box_left_r   <= box_left_nxt;
    box_right_r  <= box_right_nxt;
    box_bottom_r <= box_bottom_nxt;
    scan_col_r   <= scan_col_nxt;
    scan_row_r   <= scan_row_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    rad_zero_r   <= rad_zero_nxt;
    outer_r      <= outer_nxt;
    inner_r      <= inner_nxt;
    fg_r         <= fg_nxt;
    bg_r         <= bg_nxt;
    fill_r       <= fill_nxt;
    image_r      <= image_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
